// ===== design/lsfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfs_pkg
// Shared types, constants and the CORDIC arc table of the footprint monitor.
// ----------------------------------------------------------------------------
package lsfs_pkg;

	localparam int MAX_BEAMS_DEF = 2048;
	localparam int CORDIC_STEPS  = 16;
	localparam int ITER_W        = $clog2(CORDIC_STEPS);

	localparam logic [15:0] STEP_RST   = 16'd46;
	localparam logic [15:0] FIRST_RST  = 16'd9102;
	localparam logic [11:0] OFFSET_RST = 12'd275;
	localparam logic [15:0] RADIUS_RST = 16'd400;

	localparam logic signed [33:0] CORDIC_K30  = 34'sd652032875;
	localparam logic signed [26:0] HALF_TURN24 = 27'sd8388608;

	localparam logic [15:0] FRONT_LO = 16'd16376;
	localparam logic [15:0] FRONT_HI = 16'd49127;
	localparam logic [15:0] RIGHT_LO = 16'd8240;
	localparam logic [15:0] RIGHT_HI = 16'd24615;
	localparam logic [15:0] LEFT_LO  = 16'd40992;
	localparam logic [15:0] LEFT_HI  = 16'd57367;

	typedef enum logic [1:0] {
		REG_STEP   = 2'd0,
		REG_FIRST  = 2'd1,
		REG_OFFSET = 2'd2,
		REG_RADIUS = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ANGLE, S_ROT, S_MULX, S_MULY, S_SQX, S_SQY,
		S_CMP, S_CHK, S_VINIT, S_VEC, S_SECT, S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_ANGLE, OP_ITER, OP_MULX, OP_MULY, OP_SQX,
		OP_SQY, OP_CMP, OP_VINIT, OP_SECT, OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic iter_last;
		logic hit;
		logic nonzero;
		logic out_busy;
	} dp_stat_t;

	// Arc of step i, turn/2^24
	function automatic logic signed [26:0] arc_f(input logic [ITER_W-1:0] i);
		logic signed [26:0] a;
		unique case (i)
			4'd0:    a = 27'sd2097152;
			4'd1:    a = 27'sd1238021;
			4'd2:    a = 27'sd654136;
			4'd3:    a = 27'sd332050;
			4'd4:    a = 27'sd166669;
			4'd5:    a = 27'sd83416;
			4'd6:    a = 27'sd41718;
			4'd7:    a = 27'sd20860;
			4'd8:    a = 27'sd10430;
			4'd9:    a = 27'sd5215;
			4'd10:   a = 27'sd2608;
			4'd11:   a = 27'sd1304;
			4'd12:   a = 27'sd652;
			4'd13:   a = 27'sd326;
			4'd14:   a = 27'sd163;
			default: a = 27'sd81;
		endcase
		return a;
	endfunction

endpackage

// ===== design/lsfs_beam_if.sv =====
// ----------------------------------------------------------------------------
// lsfs_beam_if
// Beam channel: one range reading and its last-beam mark per item.
// ----------------------------------------------------------------------------
interface lsfs_beam_if;
	logic        valid;
	logic        ready;
	logic [15:0] range_mm;
	logic        last_beam;

	modport source(output valid, range_mm, last_beam, input ready);
	modport sink(input valid, range_mm, last_beam, output ready);
endinterface

// ===== design/lsfs_result_if.sv =====
// ----------------------------------------------------------------------------
// lsfs_result_if
// Result channel: sector flags and hit count of one finished scan.
// ----------------------------------------------------------------------------
interface lsfs_result_if;
	logic        valid;
	logic        ready;
	logic        front_blocked;
	logic        right_blocked;
	logic        left_blocked;
	logic [11:0] hit_total;

	modport source(output valid, front_blocked, right_blocked, left_blocked, hit_total,
		input ready);
	modport sink(input valid, front_blocked, right_blocked, left_blocked, hit_total,
		output ready);
endinterface

// ===== design/lsfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsfs_ctrl
// Sequencer that steps the datapath through one beam.
// ----------------------------------------------------------------------------
module lsfs_ctrl
	import lsfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_d = S_ANGLE;
			S_ANGLE: state_d = S_ROT;
			S_ROT:   if (stat.iter_last) state_d = S_MULX;
			S_MULX:  state_d = S_MULY;
			S_MULY:  state_d = S_SQX;
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_CMP;
			S_CMP:   state_d = S_CHK;
			S_CHK:   state_d = (stat.hit && stat.nonzero) ? S_VINIT : S_FIN;
			S_VINIT: state_d = S_VEC;
			S_VEC:   if (stat.iter_last) state_d = S_SECT;
			S_SECT:  state_d = S_FIN;
			S_FIN:   if (!stat.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_ANGLE: cmd.op = OP_ANGLE;
			S_ROT:   cmd.op = OP_ITER;
			S_MULX:  cmd.op = OP_MULX;
			S_MULY:  cmd.op = OP_MULY;
			S_SQX:   cmd.op = OP_SQX;
			S_SQY:   cmd.op = OP_SQY;
			S_CMP:   cmd.op = OP_CMP;
			S_CHK:   cmd.op = OP_NONE;
			S_VINIT: cmd.op = OP_VINIT;
			S_VEC:   cmd.op = OP_ITER;
			S_SECT:  cmd.op = OP_SECT;
			S_FIN:   if (!stat.out_busy) cmd.op = OP_FIN;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== design/lsfs_dp.sv =====
// ----------------------------------------------------------------------------
// lsfs_dp
// Datapath: config, shared CORDIC, shared multiplier, scan state, output.
// ----------------------------------------------------------------------------
module lsfs_dp
	import lsfs_pkg::*;
#(
	parameter int MAX_BEAMS = MAX_BEAMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  cfg_reg_t    cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [15:0] in_range,
	input  logic        in_last,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	lsfs_result_if.source result
);

	localparam int CNT_CAP_I = (MAX_BEAMS - 1 < 2047) ? MAX_BEAMS - 1 : 2047;
	localparam int HIT_CAP_I = (MAX_BEAMS < 4095) ? MAX_BEAMS : 4095;
	localparam logic [10:0] CNT_CAP = 11'(CNT_CAP_I);
	localparam logic [11:0] HIT_CAP = 12'(HIT_CAP_I);

	logic [15:0] step_q, first_q, radius_q;
	logic [11:0] offset_q;

	logic [15:0]        rng_q;
	logic               last_q;
	logic signed [33:0] x_q, y_q;
	logic signed [26:0] z_q;
	logic [ITER_W-1:0]  iter_q;
	logic               rot_q, flip_q;
	logic signed [25:0] px_q, py_q;
	logic [52:0]        acc_q;
	logic               hit_q, nz_q;

	logic [10:0] cnt_q;
	logic [11:0] hits_q;
	logic        front_q, right_q, left_q;

	logic        res_valid_q, res_front_q, res_right_q, res_left_q;
	logic [11:0] res_hits_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p, px_t;
	logic signed [33:0] dx, dy, c_v, s_v, px_e, py_e;
	logic               pos;
	logic [15:0]        ang, ang_f, u;
	logic signed [26:0] z_r;
	logic               flip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RST;
			first_q  <= FIRST_RST;
			offset_q <= OFFSET_RST;
			radius_q <= RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP:   step_q   <= cfg_data;
				REG_FIRST:  first_q  <= cfg_data;
				REG_OFFSET: offset_q <= cfg_data[11:0];
				REG_RADIUS: radius_q <= cfg_data;
			endcase
		end
	end

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_ANGLE: begin
				mul_a = $signed({18'b0, step_q});
				mul_b = $signed({23'b0, cnt_q});
			end
			OP_MULX: begin
				mul_a = $signed({18'b0, rng_q});
				mul_b = c_v;
			end
			OP_MULY: begin
				mul_a = $signed({18'b0, rng_q});
				mul_b = s_v;
			end
			OP_SQX: begin
				mul_a = px_e;
				mul_b = px_e;
			end
			OP_SQY: begin
				mul_a = py_e;
				mul_b = py_e;
			end
			OP_CMP: begin
				mul_a = $signed({10'b0, radius_q, 8'b0});
				mul_b = $signed({10'b0, radius_q, 8'b0});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign px_t  = mul_p - $signed({26'b0, offset_q, 30'b0});
	assign c_v   = flip_q ? -x_q : x_q;
	assign s_v   = flip_q ? -y_q : y_q;
	assign px_e  = {{8{px_q[25]}}, px_q};
	assign py_e  = {{8{py_q[25]}}, py_q};

	// Fold the beam angle into the right half plane
	assign ang   = first_q + mul_p[15:0];
	assign flip  = ang[15] ^ ang[14];
	assign ang_f = flip ? (ang ^ 16'h8000) : ang;

	assign dx  = y_q >>> iter_q;
	assign dy  = x_q >>> iter_q;
	assign pos = rot_q ? !z_q[26] : y_q[33];
	assign z_r = z_q + 27'sd128;
	assign u   = z_r[23:8];

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				rng_q  <= in_range;
				last_q <= in_last;
			end
			OP_ANGLE: begin
				x_q    <= CORDIC_K30;
				y_q    <= '0;
				z_q    <= {{3{ang_f[15]}}, ang_f, 8'b0};
				flip_q <= flip;
				rot_q  <= 1'b1;
				iter_q <= '0;
			end
			OP_ITER: begin
				if (pos) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - arc_f(iter_q);
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + arc_f(iter_q);
				end
				iter_q <= iter_q + 1'b1;
			end
			OP_MULX: px_q  <= px_t[47:22];
			OP_MULY: py_q  <= mul_p[47:22];
			OP_SQX:  acc_q <= mul_p[52:0];
			OP_SQY:  acc_q <= acc_q + mul_p[52:0];
			OP_CMP: begin
				hit_q <= acc_q < mul_p[52:0];
				nz_q  <= (px_q != '0) || (py_q != '0);
			end
			OP_VINIT: begin
				x_q    <= px_q[25] ? -px_e : px_e;
				y_q    <= px_q[25] ? -py_e : py_e;
				z_q    <= px_q[25] ? HALF_TURN24 : '0;
				rot_q  <= 1'b0;
				iter_q <= '0;
			end
			default: ;
		endcase
	end

	// Scan state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			hits_q      <= '0;
			front_q     <= 1'b0;
			right_q     <= 1'b0;
			left_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && result.ready) res_valid_q <= 1'b0;
			if (cmd.op == OP_SECT) begin
				if (u >= FRONT_LO && u <= FRONT_HI) front_q <= 1'b1;
				if (u >= RIGHT_LO && u <= RIGHT_HI) right_q <= 1'b1;
				if (u >= LEFT_LO && u <= LEFT_HI)   left_q  <= 1'b1;
			end
			if (cmd.op == OP_FIN) begin
				if (last_q) begin
					res_valid_q <= 1'b1;
					cnt_q       <= '0;
					hits_q      <= '0;
					front_q     <= 1'b0;
					right_q     <= 1'b0;
					left_q      <= 1'b0;
				end else begin
					if (cnt_q < CNT_CAP) cnt_q <= cnt_q + 1'b1;
					if (hit_q && hits_q < HIT_CAP) hits_q <= hits_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_FIN && last_q) begin
			res_front_q <= front_q;
			res_right_q <= right_q;
			res_left_q  <= left_q;
			res_hits_q  <= (hit_q && hits_q < HIT_CAP) ? hits_q + 1'b1 : hits_q;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.front_blocked = res_front_q;
	assign result.right_blocked = res_right_q;
	assign result.left_blocked  = res_left_q;
	assign result.hit_total     = res_hits_q;

	assign stat.iter_last = (iter_q == ITER_W'(CORDIC_STEPS - 1));
	assign stat.hit       = hit_q;
	assign stat.nonzero   = nz_q;
	assign stat.out_busy  = last_q && res_valid_q && !result.ready;

endmodule

// ===== design/laser_scan_footprint_sectors_core.sv =====
// ----------------------------------------------------------------------------
// laser_scan_footprint_sectors_core
// Laser scan footprint monitor: flags blocked sectors around the base.
// ----------------------------------------------------------------------------
// Flow: a beam is accepted only while idle and is finished before the next
//   is taken. Each beam runs the 16-step CORDIC rotation and six passes
//   through the shared multiplier; a hit with a nonzero point adds the
//   16-step vectoring pass. A last beam's result is registered at the end.
// Reset: asynchronous, active low; loads register defaults, clears the scan
//   state and drops any pending result. No clearing pass is needed.
module laser_scan_footprint_sectors_core
	import lsfs_pkg::*;
#(
	parameter int MAX_BEAMS = MAX_BEAMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	lsfs_beam_if.sink     beam,
	lsfs_result_if.source result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	// Beams are taken only between items; the result register decouples
	// the output side so a waiting result blocks only the next last beam.
	assign beam.ready = in_ready;

	lsfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (beam.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: angle, sin/cos rotation, hit point, distance test,
	// bearing vectoring and sector flags, plus scan accumulation.
	lsfs_dp #(
		.MAX_BEAMS (MAX_BEAMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_reg_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.in_range  (beam.range_mm),
		.in_last   (beam.last_beam),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule
